[design/ewhb_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ewhb_pkg
// Shared types and constants of the equal-width histogram binner.
// ----------------------------------------------------------------------------
package ewhb_pkg;

  localparam int unsigned BIN_SLOTS   = 1024;
  localparam int unsigned COUNT_WIDTH = 32;
  localparam int unsigned BIN_AW      = $clog2(BIN_SLOTS);
  localparam int unsigned STEP_W      = $clog2(BIN_AW);

  localparam logic [1:0] CFG_BEGIN = 2'd0;
  localparam logic [1:0] CFG_END   = 2'd1;
  localparam logic [1:0] CFG_WIDTH = 2'd2;

  localparam logic FUNC_BIN  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  localparam logic [2:0] ST_COUNTED   = 3'd0;
  localparam logic [2:0] ST_OUTSIDE   = 3'd1;
  localparam logic [2:0] ST_BEYOND    = 3'd2;
  localparam logic [2:0] ST_READ_OK   = 3'd3;
  localparam logic [2:0] ST_READ_PAST = 3'd4;

  typedef struct packed {
    logic               func;
    logic signed [31:0] sample_value;
    logic [9:0]         read_index;
  } ewhb_in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [9:0]         bin_number;
    logic signed [31:0] bin_start;
    logic [31:0]        bin_count;
  } ewhb_out_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_MUL,
    S_START,
    S_UPDATE,
    S_DONE
  } ewhb_state_e;

  typedef struct packed {
    logic clear;
    logic load;
    logic check;
    logic div_step;
    logic mul;
    logic start;
    logic update;
    logic emit;
  } ewhb_cmd_t;

  typedef struct packed {
    logic is_read;
    logic in_range;
    logic beyond;
    logic div_last;
    logic clr_last;
    logic out_free;
  } ewhb_sts_t;

endpackage
`default_nettype wire

[design/ewhb_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ewhb_ctrl
// Sequencer: clearing pass, item intake, division steps, bin update, output.
// ----------------------------------------------------------------------------
module ewhb_ctrl import ewhb_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire ewhb_sts_t sts_i,
  output ewhb_cmd_t      cmd_o
);

  ewhb_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) state_d = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.is_read) begin
          state_d = S_MUL;
        end else if (!sts_i.in_range || sts_i.beyond) begin
          state_d = S_DONE;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (sts_i.div_last) state_d = S_MUL;
      end
      S_MUL:    state_d = S_START;
      S_START:  state_d = S_UPDATE;
      S_UPDATE: state_d = S_DONE;
      S_DONE: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_CLEAR: cmd_o.clear = 1'b1;
      S_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      S_CHECK:  cmd_o.check    = 1'b1;
      S_DIV:    cmd_o.div_step = 1'b1;
      S_MUL:    cmd_o.mul      = 1'b1;
      S_START:  cmd_o.start    = 1'b1;
      S_UPDATE: cmd_o.update   = 1'b1;
      S_DONE:   cmd_o.emit     = sts_i.out_free;
      default:  cmd_o          = '0;
    endcase
  end

endmodule
`default_nettype wire

[design/ewhb_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ewhb_dp
// Datapath: config registers, restoring divider, bin start multiply-add,
// bin count memory and output register.
// ----------------------------------------------------------------------------
module ewhb_dp import ewhb_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire ewhb_in_t   in_data_i,
  input  wire logic       out_stall_i,
  output logic            out_valid_o,
  output ewhb_out_t       out_data_o,
  input  wire ewhb_cmd_t  cmd_i,
  output ewhb_sts_t       sts_o
);

  localparam int unsigned WW = 31;
  localparam int unsigned PW = WW + BIN_AW;

  logic signed [31:0]      begin_q, end_q;
  logic [WW-1:0]           width_q;
  ewhb_in_t                item_q;
  logic [31:0]             rem_q;
  logic [STEP_W-1:0]       step_q;
  logic [BIN_AW-1:0]       idx_q;
  logic [PW-1:0]           prod_q;
  logic signed [31:0]      start_q;
  logic                    rd_ok_q;
  logic [COUNT_WIDTH-1:0]  rdata_q;
  logic [BIN_AW-1:0]       clr_addr_q;
  ewhb_out_t               res_q;
  ewhb_out_t               out_q;
  logic                    out_valid_q;
  logic [COUNT_WIDTH-1:0]  mem_q [BIN_SLOTS];

  logic [WW-1:0]           eff_w;
  logic signed [32:0]      diff_v, diff_ie;
  logic                    in_range, beyond;
  logic [PW-1:0]           w_shift, rem_ext;
  logic                    div_ge;
  logic signed [PW+1:0]    start_sum;
  logic signed [31:0]      start_sat;
  logic                    rd_ok;
  logic [COUNT_WIDTH-1:0]  cnt_inc;
  logic                    mem_we;
  logic [BIN_AW-1:0]       mem_waddr;
  logic [COUNT_WIDTH-1:0]  mem_wdata;

  assign eff_w    = (width_q == '0) ? WW'(1) : width_q;
  assign diff_v   = {item_q.sample_value[31], item_q.sample_value} - {begin_q[31], begin_q};
  assign diff_ie  = {end_q[31], end_q} - {begin_q[31], begin_q};
  assign in_range = (item_q.sample_value >= begin_q) && (item_q.sample_value < end_q);
  assign beyond   = {{(PW-32){1'b0}}, diff_v[31:0]} >= {eff_w, {BIN_AW{1'b0}}};

  assign w_shift  = {{BIN_AW{1'b0}}, eff_w} << step_q;
  assign rem_ext  = {{(PW-32){1'b0}}, rem_q};
  assign div_ge   = rem_ext >= w_shift;

  assign start_sum = {{(PW-30){begin_q[31]}}, begin_q} + $signed({2'b00, prod_q});
  assign start_sat = (start_sum > $signed((PW+2)'(32'h7FFF_FFFF))) ? 32'sh7FFF_FFFF
                                                                   : start_sum[31:0];
  assign rd_ok = !diff_ie[32] && (diff_ie != '0) &&
                 (prod_q < {{(PW-32){1'b0}}, diff_ie[31:0]});

  assign cnt_inc = (rdata_q == '1) ? rdata_q : rdata_q + 1'b1;

  assign sts_o.is_read  = (item_q.func == FUNC_READ);
  assign sts_o.in_range = in_range;
  assign sts_o.beyond   = beyond;
  assign sts_o.div_last = (step_q == '0);
  assign sts_o.clr_last = (clr_addr_q == '1);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      begin_q <= 32'sd0;
      end_q   <= 32'sd67108864;
      width_q <= WW'(65536);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_BEGIN: begin_q <= cfg_data_i;
        CFG_END:   end_q   <= cfg_data_i;
        CFG_WIDTH: width_q <= cfg_data_i[WW-1:0];
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) clr_addr_q <= clr_addr_q + 1'b1;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= in_data_i;
    if (cmd_i.check) begin
      rem_q  <= diff_v[31:0];
      step_q <= STEP_W'(BIN_AW - 1);
      idx_q  <= (item_q.func == FUNC_READ) ? item_q.read_index : '0;
      if (item_q.func == FUNC_BIN && !in_range) begin
        res_q <= '{status: ST_OUTSIDE, bin_number: '0, bin_start: '0, bin_count: '0};
      end else if (item_q.func == FUNC_BIN && beyond) begin
        res_q <= '{status: ST_BEYOND, bin_number: '0, bin_start: '0, bin_count: '0};
      end
    end
    if (cmd_i.div_step) begin
      if (div_ge) begin
        rem_q         <= rem_q - w_shift[31:0];
        idx_q[step_q] <= 1'b1;
      end
      step_q <= step_q - 1'b1;
    end
    if (cmd_i.mul) prod_q <= PW'(idx_q) * PW'(eff_w);
    if (cmd_i.start) begin
      start_q <= start_sat;
      rd_ok_q <= rd_ok;
      rdata_q <= mem_q[idx_q];
    end
    if (cmd_i.update) begin
      if (item_q.func == FUNC_BIN) begin
        res_q <= '{status: ST_COUNTED, bin_number: idx_q, bin_start: start_q,
                   bin_count: 32'(cnt_inc)};
      end else if (rd_ok_q) begin
        res_q <= '{status: ST_READ_OK, bin_number: idx_q, bin_start: start_q,
                   bin_count: 32'(rdata_q)};
      end else begin
        res_q <= '{status: ST_READ_PAST, bin_number: idx_q, bin_start: '0, bin_count: '0};
      end
    end
    if (cmd_i.emit) out_q <= res_q;
  end

  assign mem_we    = cmd_i.clear || (cmd_i.update && item_q.func == FUNC_BIN);
  assign mem_waddr = cmd_i.clear ? clr_addr_q : idx_q;
  assign mem_wdata = cmd_i.clear ? '0 : cnt_inc;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

[design/equal_width_histogram_binner_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// equal_width_histogram_binner_top
// Equal-width histogram over signed Q16.16 values with a 1024-bin store.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o / in_data_i): func 0 bins
// sample_value, func 1 reads the bin at read_index. Each item gives exactly
// one item on the output channel (out_valid_o / out_stall_i / out_data_o).
// One item is in work at a time. A value that is counted passes a 10-step
// restoring divider, one multiply and one read-modify-write of the bin
// memory; a read takes the multiply and the bin memory read only; a value
// outside the interval or beyond the store skips all three. The next item
// is taken the cycle after the result moves to the output register.
// The output register lets the block take a new item while a result waits;
// while out_stall_i is high a second result waits inside until it clears.
// After reset a clearing pass zeroes the bin memory, one entry a cycle,
// with in_stall_o high. Config writes (cfg_valid_i/cfg_ready_o) are always
// taken; the user must make them only while the block is idle, since the
// block itself does not enforce it.
// ----------------------------------------------------------------------------
module equal_width_histogram_binner_top import ewhb_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire ewhb_in_t    in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output ewhb_out_t        out_data_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i
);

  ewhb_cmd_t cmd;
  ewhb_sts_t sts;

  assign cfg_ready_o = 1'b1;

  ewhb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ewhb_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("item accepted while another is in work");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!out_valid_o || !out_stall_i))
    else $error("result overwrote a stalled output");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status == ST_COUNTED || out_data_o.status == ST_OUTSIDE ||
                     out_data_o.status == ST_BEYOND || out_data_o.status == ST_READ_OK ||
                     out_data_o.status == ST_READ_PAST))
    else $error("undefined status code on output");

  a_clear_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clear |-> (in_stall_o && !cmd.update && !cmd.emit))
    else $error("item activity during clearing pass");

endmodule
`default_nettype wire

[bench/tb.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the equal-width histogram binner.
// ----------------------------------------------------------------------------
// A queue of pending items feeds a falling-edge driver that sends in bursts
// with random gaps, while the result side stalls in changing patterns. Every
// accepted item is run through a local histogram predictor that keeps its
// own copy of the bin counts and the interval settings. Each accepted result
// is compared field by field against the oldest predicted result. A short
// directed part covers the interval edges, zero width, an empty interval and
// the full signed range. Random phases follow, each with fresh settings.
// ----------------------------------------------------------------------------
module tb import ewhb_pkg::*; ;

  localparam logic [1:0] CFG_SPARE      = 2'd3;
  localparam int         WATCHDOG_LIMIT = 4000;
  localparam int         DRAIN_CYCLES   = 40;
  localparam int         RANDOM_PHASES  = 10;
  localparam int         PHASE_ITEMS    = 183;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  ewhb_in_t    in_data_i   = '0;
  logic        out_stall_i = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic [1:0]  cfg_index_i = CFG_BEGIN;
  logic [31:0] cfg_data_i  = '0;
  logic        in_stall_o;
  logic        out_valid_o;
  ewhb_out_t   out_data_o;
  logic        cfg_ready_o;

  equal_width_histogram_binner_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // local copy of the block's settings and bin store
  logic signed [31:0] cfg_begin;
  logic signed [31:0] cfg_end;
  logic [30:0]        cfg_width;
  logic [31:0]        bin_tally [BIN_SLOTS];

  ewhb_in_t  pending_items [$];
  ewhb_out_t expected_results [$];

  logic in_fire = 1'b0;
  int   quiet_cycles = 0;
  int   errors = 0;
  int   items_taken = 0;
  int   settings_applied = 0;
  int   status_seen [5];
  int   gap_left = 0;
  int   burst_left = 0;
  int   stall_mode = 0;
  int   mode_left = 0;
  int   run_left = 0;
  logic run_stall = 1'b0;

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  function automatic longint eff_width();
    return (cfg_width == '0) ? 64'sd1 : longint'(cfg_width);
  endfunction

  function automatic longint active_bin_total();
    longint span;
    longint n;
    span = longint'(cfg_end) - longint'(cfg_begin);
    if (span <= 0) return 0;
    n = (span + eff_width() - 1) / eff_width();
    return (n > longint'(BIN_SLOTS)) ? longint'(BIN_SLOTS) : n;
  endfunction

  function automatic logic [31:0] bin_start_of(longint idx);
    longint s;
    s = longint'(cfg_begin) + idx * eff_width();
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return s[31:0];
  endfunction

  function automatic ewhb_out_t histogram_predict(ewhb_in_t it);
    ewhb_out_t r;
    longint    v;
    longint    idx;
    r = '0;
    if (it.func == FUNC_BIN) begin
      v = longint'(it.sample_value);
      if (v >= longint'(cfg_begin) && v < longint'(cfg_end)) begin
        idx = (v - longint'(cfg_begin)) / eff_width();
        if (idx >= longint'(BIN_SLOTS)) begin
          r.status = ST_BEYOND;
        end else begin
          if (bin_tally[idx] != '1) bin_tally[idx] = bin_tally[idx] + 32'd1;
          r.status     = ST_COUNTED;
          r.bin_number = idx[9:0];
          r.bin_start  = bin_start_of(idx);
          r.bin_count  = bin_tally[idx];
        end
      end else begin
        r.status = ST_OUTSIDE;
      end
    end else begin
      r.bin_number = it.read_index;
      if (longint'(it.read_index) < active_bin_total()) begin
        r.status    = ST_READ_OK;
        r.bin_start = bin_start_of(longint'(it.read_index));
        r.bin_count = bin_tally[it.read_index];
      end else begin
        r.status = ST_READ_PAST;
      end
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  // result checking, prediction and settings tracking
  always @(posedge clk_i) begin
    ewhb_out_t want;
    logic      any_taken;
    if (!rst_ni) begin
      cfg_begin = 32'sd0;
      cfg_end   = 32'sd67108864;
      cfg_width = 31'd65536;
      foreach (bin_tally[i]) bin_tally[i] = '0;
      in_fire      <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      any_taken = 1'b0;
      if (out_valid_o && !out_stall_i) begin
        any_taken = 1'b1;
        if (expected_results.size() == 0) begin
          $error("result with no item outstanding: %p", out_data_o);
          errors++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", 32'(want.status), 32'(out_data_o.status));
          check_field("bin_number", 32'(want.bin_number), 32'(out_data_o.bin_number));
          check_field("bin_start", want.bin_start, out_data_o.bin_start);
          check_field("bin_count", want.bin_count, out_data_o.bin_count);
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        any_taken = 1'b1;
        case (cfg_index_i)
          CFG_BEGIN: cfg_begin = cfg_data_i;
          CFG_END:   cfg_end   = cfg_data_i;
          CFG_WIDTH: cfg_width = cfg_data_i[30:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) begin
        any_taken = 1'b1;
        want = histogram_predict(in_data_i);
        status_seen[want.status]++;
        items_taken++;
        expected_results.push_back(want);
      end
      in_fire      <= in_valid_i && !in_stall_o;
      quiet_cycles <= any_taken ? 0 : quiet_cycles + 1;
    end
  end

  // item driver: bursts with random gaps
  always @(negedge clk_i) begin
    logic     v;
    ewhb_in_t nxt;
    v   = in_valid_i;
    nxt = in_data_i;
    if (v && in_fire) v = 1'b0;
    if (!v && rst_ni) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending_items.size() > 0) begin
        nxt = pending_items.pop_front();
        v   = 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
        end
      end
    end
    in_valid_i <= v;
    in_data_i  <= nxt;
  end

  // result-side back-pressure
  always @(negedge clk_i) begin
    logic s;
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(40, 400);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0: s = 1'b0;
      1: s = 1'($urandom_range(0, 1));
      2: s = ($urandom_range(0, 3) != 0);
      default: begin
        if (run_left == 0) begin
          run_left  = $urandom_range(1, 20);
          run_stall = ~run_stall;
        end
        run_left--;
        s = run_stall;
      end
    endcase
    out_stall_i <= s;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  task automatic settle();
    while (pending_items.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic apply_config(longint lo, longint hi, longint w);
    settle();
    cfg_write(CFG_BEGIN, lo[31:0]);
    cfg_write(CFG_END, hi[31:0]);
    cfg_write(CFG_WIDTH, w[31:0]);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    settings_applied++;
  endtask

  task automatic push_bin(logic [31:0] v);
    ewhb_in_t it;
    it.func         = FUNC_BIN;
    it.sample_value = v;
    it.read_index   = 10'($urandom_range(0, 1023));
    pending_items.push_back(it);
  endtask

  task automatic push_read(logic [9:0] idx);
    ewhb_in_t it;
    it.func         = FUNC_READ;
    it.sample_value = $urandom;
    it.read_index   = idx;
    pending_items.push_back(it);
  endtask

  task automatic run_random_phase(int n);
    longint          lo;
    longint          hi;
    longint          w;
    longint          span;
    longint          nb;
    longint          off;
    longint          hot;
    longint unsigned rnd;
    case ($urandom_range(0, 4))
      0, 1: begin
        w  = longint'(1) << $urandom_range(4, 20);
        w  = w + longint'($urandom_range(0, 32'(w - 1)));
        lo = longint'($urandom_range(0, 32'h7FFF_FFFF)) - 64'sd1073741824;
        hi = lo + longint'($urandom_range(1, 1100)) * w;
        if (hi > 64'sd2147483647) hi = 64'sd2147483647;
      end
      2: begin
        lo = longint'($signed($urandom));
        hi = longint'($signed($urandom));
        w  = longint'($urandom);
      end
      3: begin
        lo = $urandom_range(0, 1) ? -64'sd2147483648 : longint'($signed($urandom)) >>> 4;
        hi = 64'sd2147483647;
        w  = longint'(1) << $urandom_range(21, 30);
      end
      default: begin
        w  = $urandom_range(0, 3);
        lo = longint'($signed($urandom)) >>> 2;
        hi = lo + longint'($urandom_range(1, 1500));
      end
    endcase
    apply_config(lo, hi, w);
    lo   = longint'(cfg_begin);
    span = longint'(cfg_end) - lo;
    nb   = active_bin_total();
    hot  = 4 * eff_width();
    repeat (n) begin
      rnd = {$urandom, $urandom};
      if ($urandom_range(0, 3) == 0) begin
        if (nb > 0 && $urandom_range(0, 4) != 0) push_read(10'(rnd % nb));
        else push_read(10'($urandom_range(0, 1023)));
      end else if (span > 0 && $urandom_range(0, 4) != 0) begin
        if ($urandom_range(0, 2) == 0 && hot < span) off = longint'(rnd % hot);
        else off = longint'(rnd % span);
        push_bin(32'(lo + off));
      end else begin
        push_bin($urandom);
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(negedge clk_i);

    // settings after reset: [0, 1024.0) in steps of 1.0
    push_bin(32'h0000_0000);
    push_bin(32'h0000_0000);
    push_bin(32'h03FF_FFFF);
    push_bin(32'h0400_0000);
    push_bin(32'hFFFF_FFFF);
    push_bin(32'h7FFF_FFFF);
    push_bin(32'h8000_0000);
    push_bin(32'h0001_8000);
    push_read(10'd0);
    push_read(10'd1);
    push_read(10'd1023);
    push_read(10'd5);

    // full signed range, widest bins; spare index is ignored
    apply_config(-64'sd2147483648, 64'sd2147483647, 64'sd2147483647);
    cfg_write(CFG_SPARE, 32'hA5A5_A5A5);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    push_bin(32'h8000_0000);
    push_bin(32'h7FFF_FFFE);
    push_bin(32'h7FFF_FFFF);
    push_bin(32'h0000_0000);
    push_read(10'd2);
    push_read(10'd3);

    // zero width acts as one, top bit of width masked
    apply_config(-64'sd512, 64'sd2147483647, 64'sh8000_0000);
    push_bin(32'hFFFF_FE00);
    push_bin(32'h0000_01FF);
    push_bin(32'h0000_0200);
    push_read(10'd1023);

    // empty interval
    apply_config(64'sd100, 64'sd100, 64'sd65536);
    push_bin(32'd100);
    push_read(10'd0);

    repeat (RANDOM_PHASES) run_random_phase(PHASE_ITEMS);

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      errors++;
    end
    $display("Covered %0d items under %0d settings incl. zero width, empty interval, full range.",
             items_taken, settings_applied + 1);
    $display("Outcomes: %0d counted, %0d outside, %0d beyond store, %0d read, %0d read past end.",
             status_seen[ST_COUNTED], status_seen[ST_OUTSIDE], status_seen[ST_BEYOND],
             status_seen[ST_READ_OK], status_seen[ST_READ_PAST]);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
